/* rtl/knel_pkg.sv */
package knel_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_BASES   = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BND_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int WORD_W     = 64;
    localparam int KEY_W      = 4 * WORD_W;
    localparam int IDX_W      = 12;
    localparam int LEN_W      = 8;
    localparam int CNT_W      = 13;
    localparam int SLOT_W     = 3;
    localparam int BASE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = CNT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0] KMER_LENGTH_RESET = LEN_W'(32);

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(7);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QLOAD,
        ST_KEY,
        ST_SEARCH,
        ST_CMP,
        ST_EMIT
    } knel_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic req_ready;
        logic mem_write;
        logic latch_query;
        logic rd_query;
        logic load_q;
        logic init_key;
        logic rd_probe;
        logic step;
        logic set_hit;
        logic set_miss;
        logic emit;
    } knel_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic req_valid;
        logic req_query;
        logic empty;
        logic eq;
        logic out_free;
        logic last_slot;
    } knel_status_t;

endpackage

/* rtl/knel_ifs.sv */
interface knel_req_if;
    import knel_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [WORD_W-1:0] word_top;
    logic [WORD_W-1:0] word_upper;
    logic [WORD_W-1:0] word_lower;
    logic [WORD_W-1:0] word_bottom;

    modport source (
        output valid, mode, entry_index, word_top, word_upper, word_lower, word_bottom,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, word_top, word_upper, word_lower, word_bottom,
        output ready
    );
endinterface

interface knel_rsp_if;
    import knel_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic [IDX_W-1:0]  neighbor_index;
    logic              last;

    modport source (
        output valid, slot, found, neighbor_index, last,
        input  ready
    );
    modport sink (
        input  valid, slot, found, neighbor_index, last,
        output ready
    );
endinterface

interface knel_cfg_if;
    import knel_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* rtl/knel_ctrl.sv */
module knel_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  knel_pkg::knel_status_t status,
    output knel_pkg::knel_cmd_t    cmd
);
    import knel_pkg::*;

    knel_state_t state_reg;
    knel_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (status.req_valid)
                begin
                    if (status.req_query)
                    begin
                        cmd.latch_query = 1'b1;
                        state_next      = ST_QREAD;
                    end
                    else
                    begin
                        cmd.mem_write = 1'b1;
                    end
                end
            end
            ST_QREAD:
            begin
                cmd.rd_query = 1'b1;
                state_next   = ST_QLOAD;
            end
            ST_QLOAD:
            begin
                cmd.load_q = 1'b1;
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                cmd.init_key = 1'b1;
                state_next   = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.empty)
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.eq)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_slot ? ST_IDLE : ST_KEY;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/knel_dp.sv */
module knel_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    knel_cfg_if.sink               cfg,
    knel_req_if.sink               req,
    knel_rsp_if.source             rsp,
    input  knel_pkg::knel_cmd_t    cmd,
    output knel_pkg::knel_status_t status
);
    import knel_pkg::*;

    logic [LEN_W-1:0]  kmer_length_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    logic [KEY_W-1:0]  mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  wr_data;

    logic [IDX_W-1:0]  ei_reg;
    logic [KEY_W-1:0]  q_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [BND_W-1:0]  lo_reg;
    logic [BND_W-1:0]  hi_reg;
    logic [BND_W-1:0]  mid_reg;
    logic [BND_W-1:0]  mid_next;
    logic [BND_W-1:0]  eff_count;
    logic              in_range;

    logic [LEN_W-1:0]  eff_bases;
    logic [LEN_W:0]    nbits;
    logic [KEY_W-1:0]  width_mask;
    logic [KEY_W-1:0]  top_hi;
    logic [KEY_W-1:0]  top_lo;
    logic [KEY_W-1:0]  pred_key;
    logic [KEY_W-1:0]  succ_key;
    logic [BASE_W-1:0] base;

    logic              res_found_reg;
    logic [IDX_W-1:0]  res_idx_reg;

    logic              rsp_valid_reg;
    logic [SLOT_W-1:0] rsp_slot_reg;
    logic              rsp_found_reg;
    logic [IDX_W-1:0]  rsp_idx_reg;
    logic              rsp_last_reg;

    // Configuration registers; the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LENGTH_RESET;
            entry_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_KMER_LENGTH: kmer_length_reg <= cfg.data[LEN_W-1:0];
                CFG_ENTRY_COUNT: entry_count_reg <= cfg.data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective length and count, clamped to the table's limits.
    always_comb
    begin
        if (kmer_length_reg == '0)
        begin
            eff_bases = LEN_W'(1);
        end
        else if (32'(kmer_length_reg) > MAX_BASES)
        begin
            eff_bases = LEN_W'(MAX_BASES);
        end
        else
        begin
            eff_bases = kmer_length_reg;
        end
        nbits     = {eff_bases, 1'b0};
        eff_count = (32'(entry_count_reg) > TABLE_DEPTH) ? BND_W'(TABLE_DEPTH)
                                                         : BND_W'(entry_count_reg);
    end

    assign in_range = 32'(ei_reg) < 32'(eff_count);

    // Width mask and the bit pair where a prepended base lands.
    always_comb
    begin
        for (int i = 0; i < KEY_W; i++)
        begin
            width_mask[i] = (i < int'(nbits));
            top_hi[i]     = (i == int'(nbits) - 1);
            top_lo[i]     = (i == int'(nbits) - 2);
        end
    end

    // Neighbor key for the current slot.
    assign base     = slot_reg[BASE_W-1:0];
    assign pred_key = ((q_reg >> BASE_W) | (top_hi & {KEY_W{base[1]}})
                      | (top_lo & {KEY_W{base[0]}})) & width_mask;
    assign succ_key = ((q_reg << BASE_W) | KEY_W'(base)) & width_mask;
    assign key_next = slot_reg[SLOT_W-1] ? succ_key : pred_key;

    // Probe position of the binary search over [lo, hi).
    assign mid_next = lo_reg + ((hi_reg - lo_reg - BND_W'(1)) >> 1);

    // Table memory: one write port, one registered read port.
    assign mem_we  = cmd.mem_write && (32'(req.entry_index) < TABLE_DEPTH);
    assign wr_addr = ADDR_W'(req.entry_index);
    assign wr_data = {req.word_top, req.word_upper, req.word_lower, req.word_bottom};
    assign rd_en   = cmd.rd_query || cmd.rd_probe;
    assign rd_addr = cmd.rd_probe ? mid_next[ADDR_W-1:0] : ADDR_W'(ei_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Slot counter runs over the eight neighbors of a query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (cmd.latch_query)
        begin
            slot_reg <= '0;
        end
        else if (cmd.emit)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // Query word, search key, bounds and result.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_query)
        begin
            ei_reg <= req.entry_index;
        end
        if (cmd.load_q)
        begin
            q_reg <= rd_data_reg & width_mask;
        end
        if (cmd.init_key)
        begin
            key_reg <= key_next;
            lo_reg  <= '0;
            hi_reg  <= in_range ? eff_count : '0;
        end
        else if (cmd.step)
        begin
            if (rd_data_reg > key_reg)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= mid_reg + BND_W'(1);
            end
        end
        if (cmd.rd_probe)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.set_hit)
        begin
            res_found_reg <= 1'b1;
            res_idx_reg   <= IDX_W'(mid_reg);
        end
        else if (cmd.set_miss)
        begin
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_slot_reg  <= slot_reg;
            rsp_found_reg <= res_found_reg;
            rsp_idx_reg   <= res_idx_reg;
            rsp_last_reg  <= (slot_reg == LAST_SLOT);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.slot           = rsp_slot_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.neighbor_index = rsp_idx_reg;
    assign rsp.last           = rsp_last_reg;
    assign req.ready          = cmd.req_ready;

    // Status toward the controller
    always_comb
    begin
        status.req_valid = req.valid;
        status.req_query = (req.mode == MODE_QUERY);
        status.empty     = (lo_reg >= hi_reg);
        status.eq        = (rd_data_reg == key_reg);
        status.out_free  = !rsp_valid_reg || rsp.ready;
        status.last_slot = (slot_reg == LAST_SLOT);
    end

`ifndef ASSERT_OFF
    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid_reg || rsp.ready))
        else $error("result register overwritten");

    // The table's write port and read port are never used together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && rd_en))
        else $error("memory read and write collide");

    // Every probe lies inside the current search window.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_probe |-> (mid_next >= lo_reg && mid_next < hi_reg))
        else $error("probe outside search window");

    // The last mark travels only with the eighth neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_last_reg) |-> (rsp_slot_reg == LAST_SLOT))
        else $error("last mark on wrong slot");
`endif

endmodule

/* rtl/kmer_neighbor_edge_lookup_core.sv */
// K-mer neighbor lookup over a sorted table of 2-bit-packed k-mers.
// cfg: register 0 sets the k-mer length in bases, register 1 the number of
// valid entries. Write them only while no query is in flight.
// req: mode 0 stores the four words at entry_index (no result);
// mode 1 queries the neighbors of the entry at entry_index.
// rsp: each query returns eight results in slot order 0..7, the four
// predecessors then the four successors, with last set on slot 7.
// Sequence: a query reads its k-mer from the table and loads it, then for
// each slot forms the key, runs binary-search probes (each a memory read,
// then a 256-bit compare) until a match or an empty window, and emits the
// result. The single table read port serves the fetch and every probe.
// A write request is taken every cycle while the block is idle.
// Results sit in an output register; when the receiver stalls, the search
// of the next slot waits, and a new request is taken once the eighth
// result is in that register. Reset clears the state machine, the output
// valid and the registers (length 32, count 0); table contents are
// undefined until written.
module kmer_neighbor_edge_lookup_core (
    input  logic       clk,
    input  logic       rst_n,
    knel_cfg_if.sink   cfg,
    knel_req_if.sink   req,
    knel_rsp_if.source rsp
);
    import knel_pkg::*;

    knel_cmd_t    cmd;
    knel_status_t status;

    knel_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    knel_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

/* tb/kmer_neighbor_checker.sv */
module kmer_neighbor_checker
    import knel_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    knel_cfg_if  cfg,
    knel_req_if  req,
    knel_rsp_if  rsp,
    output int   pending,
    output int   mismatches,
    output int   results_checked,
    output int   neighbor_hits
);

    localparam int SLOT_COUNT = 8;
    localparam int BASE_COUNT = 4;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic [IDX_W-1:0]  neighbor_index;
        logic              last;
    } neighbor_t;

    // Shadow copy of the k-mer table and of the two registers.
    logic [KEY_W-1:0] kmer_table [TABLE_DEPTH];
    logic [LEN_W-1:0] kmer_length;
    logic [CNT_W-1:0] entry_count;
    neighbor_t        expected_neighbors [$];

    // Two bits per base, with the length clamped to 1..MAX_BASES.
    function automatic int unsigned kmer_bits();
        int unsigned bases;
        bases = kmer_length;
        if (bases == 0)
        begin
            bases = 1;
        end
        if (bases > MAX_BASES)
        begin
            bases = MAX_BASES;
        end
        return BASE_W * bases;
    endfunction

    function automatic logic [KEY_W-1:0] width_mask(input int unsigned nbits);
        if (nbits >= KEY_W)
        begin
            return '1;
        end
        return (KEY_W'(1) << nbits) - KEY_W'(1);
    endfunction

    // Binary search over the first live entries, stopping at the first equal probe.
    function automatic bit locate_kmer(input logic [KEY_W-1:0] key, input int unsigned live,
                                       output int pos);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = int'(live) - 1;
        pos = 0;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (kmer_table[mid] == key)
            begin
                pos = mid;
                return 1'b1;
            end
            if (kmer_table[mid] > key)
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    // Form the four predecessors and four successors of one entry and look each up.
    function automatic void predict_neighbors(input logic [IDX_W-1:0] origin);
        logic [KEY_W-1:0]  mask;
        logic [KEY_W-1:0]  seed;
        logic [KEY_W-1:0]  probe;
        logic [BASE_W-1:0] base;
        int unsigned       nbits;
        int unsigned       live;
        int                pos;
        int                s;
        neighbor_t         nb;
        nbits = kmer_bits();
        mask  = width_mask(nbits);
        live  = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
        seed  = (origin < live) ? (kmer_table[origin] & mask) : '0;
        for (s = 0; s < SLOT_COUNT; s++)
        begin
            base = BASE_W'(s % BASE_COUNT);
            if (s < BASE_COUNT)
            begin
                probe = (seed >> BASE_W) | (KEY_W'(base) << (nbits - BASE_W));
            end
            else
            begin
                probe = (seed << BASE_W) | KEY_W'(base);
            end
            probe             = probe & mask;
            nb.slot           = SLOT_W'(s);
            nb.found          = 1'b0;
            nb.neighbor_index = '0;
            nb.last           = (SLOT_W'(s) == LAST_SLOT);
            if (origin < live && locate_kmer(probe, live, pos))
            begin
                nb.found          = 1'b1;
                nb.neighbor_index = IDX_W'(pos);
            end
            expected_neighbors.insert(expected_neighbors.size(), nb);
        end
    endfunction

    function automatic void compare_field(input string field, input logic [IDX_W-1:0] want,
                                          input logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Track register writes and requests, then check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        neighbor_t want;
        if (!rst_n)
        begin
            kmer_length = KMER_LENGTH_RESET;
            entry_count = '0;
            expected_neighbors.delete();
            pending         = 0;
            mismatches      = 0;
            results_checked = 0;
            neighbor_hits   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_KMER_LENGTH: kmer_length = cfg.data[LEN_W-1:0];
                    CFG_ENTRY_COUNT: entry_count = cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_WRITE)
                begin
                    kmer_table[req.entry_index] = {req.word_top, req.word_upper,
                                                   req.word_lower, req.word_bottom};
                end
                else
                begin
                    predict_neighbors(req.entry_index);
                end
            end

            if (rsp.valid && rsp.ready)
            begin
                results_checked++;
                if (expected_neighbors.size() == 0)
                begin
                    $error("unexpected result: slot %0d with no query outstanding", rsp.slot);
                    mismatches++;
                end
                else
                begin
                    want = expected_neighbors.pop_front();
                    if (want.found)
                    begin
                        neighbor_hits++;
                    end
                    compare_field("slot", want.slot, rsp.slot);
                    compare_field("found", want.found, rsp.found);
                    compare_field("neighbor_index", want.neighbor_index, rsp.neighbor_index);
                    compare_field("last", want.last, rsp.last);
                end
            end

            pending = expected_neighbors.size();
        end
    end

endmodule

/* tb/tb_kmer_neighbor_edge_lookup_core.sv */
module tb_kmer_neighbor_edge_lookup_core;
    import knel_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_GUARD   = 8;
    localparam int TAIL_CYCLES   = 32;
    localparam int RANDOM_PHASES = 9;
    localparam int BASE_COUNT    = 4;
    localparam int BIG_KMER_LEN  = 6;

    // Register index outside the defined set; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = '1;

    logic clk = 1'b0;
    logic rst_n;

    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count = 0;
    int write_total = 0;
    int query_total = 0;
    int table_loads = 0;
    int live_count  = 0;

    int pending;
    int mismatches;
    int results_checked;
    int neighbor_hits;

    logic [KEY_W-1:0] walk_kmers [$];

    knel_cfg_if cfg_ch ();
    knel_req_if req_ch ();
    knel_rsp_if rsp_ch ();

    kmer_neighbor_edge_lookup_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    kmer_neighbor_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_ch),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .pending         (pending),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .neighbor_hits   (neighbor_hits)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver stalls at random according to the current idle rate.
    always @(posedge clk)
    begin
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic int unsigned kmer_width_bits(input logic [CFG_DATA_W-1:0] raw_len);
        int unsigned bases;
        bases = raw_len[LEN_W-1:0];
        if (bases == 0)
        begin
            bases = 1;
        end
        if (bases > MAX_BASES)
        begin
            bases = MAX_BASES;
        end
        return BASE_W * bases;
    endfunction

    // Sorted k-mers from a random walk of successors, so many neighbors are present.
    function automatic void build_walk(input int n, input int unsigned nbits,
                                       input bit allow_dups);
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] cur;
        int               pos;
        int               tries;
        mask  = (nbits >= KEY_W) ? '1 : ((KEY_W'(1) << nbits) - KEY_W'(1));
        cur   = rand_key() & mask;
        tries = 0;
        walk_kmers.delete();
        while (walk_kmers.size() < n && tries < 8 * n + 16)
        begin
            tries++;
            pos = 0;
            while (pos < walk_kmers.size() && walk_kmers[pos] < cur)
            begin
                pos++;
            end
            if (allow_dups || pos == walk_kmers.size() || walk_kmers[pos] != cur)
            begin
                walk_kmers.insert(pos, cur);
            end
            if ($urandom_range(9) == 0)
            begin
                cur = rand_key() & mask;
            end
            else
            begin
                cur = ((cur << BASE_W) | KEY_W'($urandom_range(BASE_COUNT - 1))) & mask;
            end
        end
    endfunction

    // One request; the sender may idle first, and valid stays up until accepted.
    task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx,
                                input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.entry_index <= idx;
        {req_ch.word_top, req_ch.word_upper, req_ch.word_lower, req_ch.word_bottom} <= key;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        if (mode == MODE_WRITE)
        begin
            write_total++;
        end
        else
        begin
            query_total++;
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_ENTRY_COUNT)
        begin
            table_loads++;
        end
        @(posedge clk);
    endtask

    // Wait until every predicted result has arrived, then let the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GUARD) @(posedge clk);
    endtask

    // Set the length, store a fresh sorted walk and publish its entry count or a shorter one.
    task automatic load_table(input logic [CFG_DATA_W-1:0] raw_len, input int n,
                              input bit allow_dups, input bit short_count);
        int i;
        drain();
        write_register(CFG_KMER_LENGTH, raw_len);
        build_walk(n, kmer_width_bits(raw_len), allow_dups);
        for (i = 0; i < walk_kmers.size(); i++)
        begin
            send_request(MODE_WRITE, IDX_W'(i), walk_kmers[i]);
        end
        live_count = short_count ? $urandom_range(walk_kmers.size()) : walk_kmers.size();
        drain();
        write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(live_count));
    endtask

    // Mostly queries of live entries, some past the count, a few stray writes.
    task automatic mixed_requests(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (live_count > 0 && pick < 80)
            begin
                send_request(MODE_QUERY, IDX_W'($urandom_range(live_count - 1)), rand_key());
            end
            else if (pick < 90 || live_count == 0)
            begin
                send_request(MODE_QUERY, IDX_W'($urandom_range(live_count, TABLE_DEPTH - 1)),
                             rand_key());
            end
            else if (pick < 95)
            begin
                send_request(MODE_WRITE, IDX_W'($urandom_range(live_count, TABLE_DEPTH - 1)),
                             rand_key());
            end
            else
            begin
                // Overwriting a live entry leaves the table unsorted.
                send_request(MODE_WRITE, IDX_W'($urandom_range(live_count - 1)), rand_key());
            end
        end
    endtask

    initial
    begin
        int               i;
        int               phase;
        int               pick;
        logic [CFG_DATA_W-1:0] raw_len;
        logic [KEY_W-1:0] odd_entry;

        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_WRITE;
        req_ch.entry_index <= '0;
        req_ch.word_top    <= '0;
        req_ch.word_upper  <= '0;
        req_ch.word_lower  <= '0;
        req_ch.word_bottom <= '0;
        tx_idle_pct = 30;
        rx_idle_pct = 48;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table after reset: every neighbor misses.
        send_request(MODE_QUERY, '0, '1);

        // Length zero counts as one base; all four one-base k-mers are stored.
        drain();
        write_register(CFG_KMER_LENGTH, '0);
        for (i = 0; i < BASE_COUNT; i++)
        begin
            send_request(MODE_WRITE, IDX_W'(i), KEY_W'(i));
        end
        drain();
        write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(BASE_COUNT));
        live_count = BASE_COUNT;
        send_request(MODE_QUERY, '0, '0);
        send_request(MODE_QUERY, IDX_W'(BASE_COUNT - 1), rand_key());

        // A length above the maximum counts as the full 128 bases.
        load_table(CFG_DATA_W'(8'hFF), 5, 1'b0, 1'b0);
        send_request(MODE_QUERY, '0, rand_key());
        send_request(MODE_QUERY, IDX_W'(live_count - 1), rand_key());
        send_request(MODE_QUERY, '1, rand_key());

        // Only the low byte of the length counts, giving three bases. The table has
        // a duplicate pair and a last entry with junk above the k-mer width.
        drain();
        write_register(CFG_KMER_LENGTH, 13'h1F03);
        odd_entry              = rand_key();
        odd_entry[KEY_W-1]     = 1'b1;
        odd_entry[5:0]         = 6'h11;
        send_request(MODE_WRITE, IDX_W'(0), KEY_W'(6'h05));
        send_request(MODE_WRITE, IDX_W'(1), KEY_W'(6'h05));
        send_request(MODE_WRITE, IDX_W'(2), KEY_W'(6'h14));
        send_request(MODE_WRITE, IDX_W'(3), odd_entry);
        drain();
        write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(4));
        live_count = 4;
        send_request(MODE_QUERY, IDX_W'(0), rand_key());
        send_request(MODE_QUERY, IDX_W'(3), rand_key());

        // A write to an unused register index must leave the table setup alone.
        drain();
        write_register(CFG_SPARE_INDEX, '1);
        send_request(MODE_QUERY, IDX_W'(2), rand_key());

        // Random table setups, switching the idle pattern every third phase.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 48;
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 30;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                raw_len = '0;
            end
            else if (pick == 1)
            begin
                raw_len = CFG_DATA_W'($urandom_range(MAX_BASES + 1, 255));
            end
            else if (pick < 6)
            begin
                raw_len = CFG_DATA_W'($urandom_range(1, BIG_KMER_LEN));
            end
            else
            begin
                raw_len = CFG_DATA_W'($urandom_range(BIG_KMER_LEN + 1, MAX_BASES));
            end
            load_table(raw_len, $urandom_range(1, 16), $urandom_range(3) == 0,
                       $urandom_range(4) == 0);
            mixed_requests($urandom_range(8, 12));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d table writes and %0d neighbor queries over %0d table setups.",
                 write_total, query_total, table_loads);
        $display("Checked %0d neighbor results, %0d of them found in the table.",
                 results_checked, neighbor_hits);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
